@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the grid value learner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/gtd_pkg.sv @@
// Shared types and constants for the grid TD(0) value learner.
`default_nettype none

package gtd_pkg;

	// Grid geometry: a cell index is {row, col}.
	localparam int ROW_W = 4;
	localparam int COL_W = 4;
	localparam int MAX_ROWS = 1 << ROW_W;
	localparam int MAX_COLS = 1 << COL_W;
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int DIM_W = ROW_W + 1;

	// Fixed point: values Q16.16, factors Q0.16 with 1.0 included.
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int FACTOR_W = FRAC_BITS + 1;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRAC_BITS);

	// Configuration port.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = FACTOR_W;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = DIM_W'(3);
	localparam logic [DIM_W-1:0] RST_GRID_WIDTH = DIM_W'(4);
	localparam logic [ROW_W-1:0] RST_GOAL_ROW = ROW_W'(2);
	localparam logic [COL_W-1:0] RST_GOAL_COL = COL_W'(3);
	localparam logic [FACTOR_W-1:0] RST_DISCOUNT = FACTOR_W'(58982);
	localparam logic [FACTOR_W-1:0] RST_LEARN_RATE = FACTOR_W'(655);

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_STEP = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_HEIGHT = 3'd0,
		REG_GRID_WIDTH  = 3'd1,
		REG_GOAL_ROW    = 3'd2,
		REG_GOAL_COL    = 3'd3,
		REG_DISCOUNT    = 3'd4,
		REG_LEARN_RATE  = 3'd5
	} reg_idx_t;

	// Sequencer commands to the datapath, at most one per cycle.
	typedef struct packed {
		logic clear;
		logic accept;
		logic issue;
		logic select;
		logic delta;
		logic scale;
		logic finish;
	} gtd_cmd_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		cmd_code_t op;
		logic      goal_hit;
		logic      clear_last;
	} gtd_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/gtd_ctrl.sv @@
// Sequencer for the grid value learner: walks each item through its steps.
`default_nettype none
`include "assert_macros.svh"

module gtd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire gtd_pkg::gtd_stat_t stat,
	output gtd_pkg::gtd_cmd_t      cmd
);
	import gtd_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_SELECT,
		ST_DELTA,
		ST_SCALE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Command decode; the result is loaded only when the output register is free.
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		cmd.clear = (state_q == ST_CLEAR);
		cmd.accept = in_ready && in_valid;
		cmd.issue = (state_q == ST_ISSUE);
		cmd.select = (state_q == ST_SELECT);
		cmd.delta = (state_q == ST_DELTA);
		cmd.scale = (state_q == ST_SCALE);
		cmd.finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				// The tables are swept once after reset before any item is taken.
				ST_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (stat.op == CMD_STEP && !stat.goal_hit) begin
						state_q <= ST_SELECT;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SELECT: state_q <= ST_DELTA;
				ST_DELTA:  state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_one_command, $onehot0(cmd), "more than one datapath command in a cycle")
	`ASSERT_CLK(a_accept_busy, in_valid && in_ready |=> !in_ready, "ready held after transfer")
	`ASSERT_CLK(a_finish_shows, cmd.finish |=> out_valid && in_ready, "finished item not presented")

endmodule

`default_nettype wire

@@ rtl/core/gtd_datapath.sv @@
// Datapath of the grid value learner: config, tables, TD update arithmetic.
`default_nettype none
`include "assert_macros.svh"

module gtd_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire gtd_pkg::gtd_cmd_t                   cmd,
	output gtd_pkg::gtd_stat_t                       stat,
	input  wire logic                                cfg_we,
	input  wire logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [gtd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [1:0]                          command,
	input  wire logic [gtd_pkg::ROW_W-1:0]           cell_row,
	input  wire logic [gtd_pkg::COL_W-1:0]           cell_col,
	input  wire logic                                wall_bit,
	input  wire logic signed [gtd_pkg::VALUE_BITS-1:0] cell_reward,
	input  wire logic [1:0]                          move_dir,
	output logic signed [gtd_pkg::VALUE_BITS-1:0]    value_out,
	output logic [gtd_pkg::ROW_W-1:0]                agent_row,
	output logic [gtd_pkg::COL_W-1:0]                agent_col,
	output logic                                     episode_end,
	output logic                                     saturated
);
	import gtd_pkg::*;

	// Widths of the update arithmetic.
	localparam int PG_W = VALUE_BITS + FACTOR_W + 1;
	localparam int G_W = PG_W - FRAC_BITS;
	localparam int DW = G_W + 1;
	localparam int PA_W = DW + FACTOR_W + 1;
	localparam int UW = PA_W - FRAC_BITS;
	localparam int NW = UW + 1;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
	localparam logic signed [NW-1:0] VMAX =
		{{(NW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
	localparam logic signed [NW-1:0] VMIN = ~VMAX;
	localparam logic signed [VALUE_BITS-1:0] VMAX_OUT = VMAX[VALUE_BITS-1:0];
	localparam logic signed [VALUE_BITS-1:0] VMIN_OUT = VMIN[VALUE_BITS-1:0];

	// Configuration; sizes and factors are stored already clamped to their usable range.
	logic [DIM_W-1:0]    rows_q, cols_q;
	logic [ROW_W-1:0]    goal_row_q;
	logic [COL_W-1:0]    goal_col_q;
	logic [FACTOR_W-1:0] gamma_q, alpha_q;
	logic [DIM_W-1:0]    dim_in;
	logic [FACTOR_W-1:0] factor_in;

	// Agent position.
	logic [ROW_W-1:0] agent_row_q;
	logic [COL_W-1:0] agent_col_q;

	// Captured input item.
	cmd_code_t                     op_q;
	logic [ROW_W-1:0]              row_q;
	logic [COL_W-1:0]              col_q;
	logic                          wall_q;
	logic signed [VALUE_BITS-1:0]  reward_q;
	dir_t                          dir_q;

	// Tables and the address of the clearing pass.
	logic signed [VALUE_BITS-1:0] value_mem [CELLS];
	logic signed [VALUE_BITS-1:0] reward_mem [CELLS];
	logic                         wall_mem [CELLS];
	logic [ADDR_W-1:0]            clr_addr_q;

	// Read data registers.
	logic signed [VALUE_BITS-1:0] va_q, vb_q, ra_q, rb_q;
	logic                         wa_q;

	// Move decode.
	logic [ADDR_W-1:0] cur_addr, cand_addr, va_addr, cand_addr_q, nxt_addr_q;
	logic [DIM_W-1:0]  nr, nc;
	logic              under, oob, oob_q, goal_hit_q, blocked;

	// Arithmetic registers.
	logic signed [VALUE_BITS-1:0] vcur_q, rew_q, vnext;
	logic signed [FACTOR_W:0]     gamma_s, alpha_s;
	logic signed [PG_W-1:0]       prod_d, prod_q, g_sum;
	logic signed [G_W-1:0]        g_val;
	logic signed [DW-1:0]         delta_d, delta_q;
	logic signed [PA_W-1:0]       pa, pa_sum;
	logic signed [UW-1:0]         upd_d, upd_q;
	logic signed [NW-1:0]         nv;
	logic signed [VALUE_BITS-1:0] nv_clamp;
	logic                         nv_sat, step_upd, reach_goal;
	logic                         out_at_limit, out_home;

	// Clamp helpers for configuration writes.
	always_comb begin
		dim_in = cfg_data[DIM_W-1:0];
		if (dim_in == '0) begin
			dim_in = DIM_W'(1);
		end
		if (dim_in > DIM_W'(MAX_ROWS)) begin
			dim_in = DIM_W'(MAX_ROWS);
		end
		factor_in = cfg_data[FACTOR_W-1:0];
		if (factor_in > FACTOR_ONE) begin
			factor_in = FACTOR_ONE;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RST_GRID_HEIGHT;
			cols_q <= RST_GRID_WIDTH;
			goal_row_q <= RST_GOAL_ROW;
			goal_col_q <= RST_GOAL_COL;
			gamma_q <= RST_DISCOUNT;
			alpha_q <= RST_LEARN_RATE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GRID_HEIGHT: rows_q <= dim_in;
				REG_GRID_WIDTH:  cols_q <= dim_in;
				REG_GOAL_ROW:    goal_row_q <= cfg_data[ROW_W-1:0];
				REG_GOAL_COL:    goal_col_q <= cfg_data[COL_W-1:0];
				REG_DISCOUNT:    gamma_q <= factor_in;
				REG_LEARN_RATE:  alpha_q <= factor_in;
				default: ;
			endcase
		end
	end

	// Capture the item at its transfer.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= cmd_code_t'(command);
			row_q <= cell_row;
			col_q <= cell_col;
			wall_q <= wall_bit;
			reward_q <= cell_reward;
			dir_q <= dir_t'(move_dir);
		end
	end

	// Candidate target cell and its bounds check.
	always_comb begin
		cur_addr = {agent_row_q, agent_col_q};
		nr = {1'b0, agent_row_q};
		nc = {1'b0, agent_col_q};
		under = 1'b0;
		case (dir_q)
			DIR_RIGHT: nc = nc + DIM_W'(1);
			DIR_DOWN:  nr = nr + DIM_W'(1);
			DIR_LEFT: begin
				under = (agent_col_q == '0);
				nc = nc - DIM_W'(1);
			end
			DIR_UP: begin
				under = (agent_row_q == '0);
				nr = nr - DIM_W'(1);
			end
			default: ;
		endcase
		oob = under || (nr >= rows_q) || (nc >= cols_q);
		cand_addr = {nr[ROW_W-1:0], nc[COL_W-1:0]};
		va_addr = (op_q == CMD_READ) ? {row_q, col_q} : cur_addr;
	end

	assign stat.op = op_q;
	assign stat.goal_hit = (agent_row_q == goal_row_q) && (agent_col_q == goal_col_q);
	assign stat.clear_last = (clr_addr_q == '1);

	// Clearing pass after reset: one entry of every table per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// Table ports: reads in the issue step, cell load there too, value write at finish.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			va_q <= value_mem[va_addr];
			vb_q <= value_mem[cand_addr];
			ra_q <= reward_mem[cand_addr];
			wa_q <= wall_mem[cand_addr];
			rb_q <= reward_mem[cur_addr];
			cand_addr_q <= cand_addr;
			oob_q <= oob;
			goal_hit_q <= stat.goal_hit;
		end
		if (cmd.issue && op_q == CMD_LOAD) begin
			reward_mem[{row_q, col_q}] <= reward_q;
			wall_mem[{row_q, col_q}] <= wall_q;
		end else if (cmd.clear) begin
			reward_mem[clr_addr_q] <= '0;
			wall_mem[clr_addr_q] <= 1'b0;
		end
		if (step_upd) begin
			value_mem[cur_addr] <= nv_clamp;
		end else if (cmd.clear) begin
			value_mem[clr_addr_q] <= '0;
		end
	end

	always_comb begin
		blocked = oob_q || wa_q;
		vnext = blocked ? va_q : vb_q;
		gamma_s = $signed({1'b0, gamma_q});
		alpha_s = $signed({1'b0, alpha_q});
		prod_d = gamma_s * vnext;
	end

	// Select step: pick the target and form gamma times its value.
	always_ff @(posedge clk) begin
		if (cmd.select) begin
			nxt_addr_q <= blocked ? cur_addr : cand_addr_q;
			rew_q <= blocked ? rb_q : ra_q;
			vcur_q <= va_q;
			prod_q <= prod_d;
		end
	end

	// Delta step: round the discounted value half up, then take the TD error.
	always_comb begin
		g_sum = prod_q + PG_W'(ROUND_HALF);
		g_val = g_sum[PG_W-1:FRAC_BITS];
		delta_d = DW'(rew_q) + DW'(g_val) - DW'(vcur_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.delta) begin
			delta_q <= delta_d;
		end
	end

	// Scale step: alpha times the error, rounded half up.
	always_comb begin
		pa = alpha_s * delta_q;
		pa_sum = pa + PA_W'(ROUND_HALF);
		upd_d = pa_sum[PA_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			upd_q <= upd_d;
		end
	end

	// Finish step: new value with saturation.
	always_comb begin
		nv = NW'(vcur_q) + NW'(upd_q);
		nv_sat = 1'b0;
		nv_clamp = nv[VALUE_BITS-1:0];
		if (nv > VMAX) begin
			nv_clamp = VMAX_OUT;
			nv_sat = 1'b1;
		end
		if (nv < VMIN) begin
			nv_clamp = VMIN_OUT;
			nv_sat = 1'b1;
		end
		step_upd = cmd.finish && (op_q == CMD_STEP) && !goal_hit_q;
		reach_goal = (nxt_addr_q == {goal_row_q, goal_col_q});
	end

	// Agent position update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agent_row_q <= '0;
			agent_col_q <= '0;
		end else if (cmd.finish && op_q == CMD_STEP) begin
			if (goal_hit_q || reach_goal) begin
				agent_row_q <= '0;
				agent_col_q <= '0;
			end else begin
				agent_row_q <= nxt_addr_q[ADDR_W-1:COL_W];
				agent_col_q <= nxt_addr_q[COL_W-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			value_out <= '0;
			agent_row <= agent_row_q;
			agent_col <= agent_col_q;
			episode_end <= 1'b0;
			saturated <= 1'b0;
			case (op_q)
				CMD_READ: value_out <= va_q;
				CMD_STEP: begin
					if (goal_hit_q) begin
						value_out <= va_q;
						agent_row <= '0;
						agent_col <= '0;
						episode_end <= 1'b1;
					end else begin
						value_out <= nv_clamp;
						saturated <= nv_sat;
						episode_end <= reach_goal;
						agent_row <= reach_goal ? '0 : nxt_addr_q[ADDR_W-1:COL_W];
						agent_col <= reach_goal ? '0 : nxt_addr_q[COL_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Result checks.
	assign out_at_limit = (value_out == VMAX_OUT) || (value_out == VMIN_OUT);
	assign out_home = (agent_row == '0) && (agent_col == '0);

	`ASSERT_CLK(a_sat_at_limit, cmd.finish |=> !saturated || out_at_limit, "saturation off limit")
	`ASSERT_CLK(a_episode_home, cmd.finish |=> !episode_end || out_home, "episode end away from home")
	`ASSERT_NEVER(a_clear_overlap, cmd.clear && (cmd.issue || step_upd), "table clear during an item")

endmodule

`default_nettype wire

@@ rtl/core/grid_td0_value_learner.sv @@
// Top level of the grid TD(0) state-value learner.
// Usage:
//   Items enter on the in_valid/in_ready channel: command selects load cell, take step
//   or read cell value. Each item yields exactly one result on out_valid/out_ready.
//   Configuration registers (grid size, goal, discount, learn rate) are written through
//   cfg_we/cfg_index/cfg_data, one per cycle, while no item is in flight.
// Timing:
//   A step runs through the issue, select, delta, scale and finish states: the tables
//   are read once, then the gamma multiply, the TD error, the alpha multiply and the
//   write-back each take a state of the shared sequencer. Load, read and idle commands,
//   and a step on the goal, go from issue to finish, where the result is registered.
//   The sequencer handles one item at a time; ready is high only while it is idle.
// Stalls:
//   A finished result sits in the output register until transferred. The next item is
//   accepted meanwhile, and its result waits in the last step until the register frees.
// Reset:
//   arst_n puts the agent at (0,0) and loads the default configuration, then a clearing
//   pass zeroes the value, reward and wall tables one entry a cycle. It sweeps every entry,
//   and in_ready stays low until it is done.
`default_nettype none

module grid_td0_value_learner (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [gtd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [gtd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [1:0]                            command,
	input  wire logic [gtd_pkg::ROW_W-1:0]             cell_row,
	input  wire logic [gtd_pkg::COL_W-1:0]             cell_col,
	input  wire logic                                  wall_bit,
	input  wire logic signed [gtd_pkg::VALUE_BITS-1:0] cell_reward,
	input  wire logic [1:0]                            move_dir,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [gtd_pkg::VALUE_BITS-1:0]      value_out,
	output logic [gtd_pkg::ROW_W-1:0]                  agent_row,
	output logic [gtd_pkg::COL_W-1:0]                  agent_col,
	output logic                                       episode_end,
	output logic                                       saturated
);
	import gtd_pkg::*;

	gtd_cmd_t  cmd;
	gtd_stat_t stat;

	// Sequencer.
	gtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Tables and arithmetic.
	gtd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.wall_bit    (wall_bit),
		.cell_reward (cell_reward),
		.move_dir    (move_dir),
		.value_out   (value_out),
		.agent_row   (agent_row),
		.agent_col   (agent_col),
		.episode_end (episode_end),
		.saturated   (saturated)
	);

endmodule

`default_nettype wire

@@ tb/td0_learner_checker.sv @@
// Checker for the grid TD(0) value learner: predicts every result and compares each transfer.
module td0_learner_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gtd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gtd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [1:0]                            command,
	input  logic [gtd_pkg::ROW_W-1:0]             cell_row,
	input  logic [gtd_pkg::COL_W-1:0]             cell_col,
	input  logic                                  wall_bit,
	input  logic signed [gtd_pkg::VALUE_BITS-1:0] cell_reward,
	input  logic [1:0]                            move_dir,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [gtd_pkg::VALUE_BITS-1:0] value_out,
	input  logic [gtd_pkg::ROW_W-1:0]             agent_row,
	input  logic [gtd_pkg::COL_W-1:0]             agent_col,
	input  logic                                  episode_end,
	input  logic                                  saturated,
	output int                                    fail_count,
	output int                                    pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gtd_pkg::*;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [ROW_W-1:0]             row;
		logic [COL_W-1:0]             col;
		logic                         ended;
		logic                         clamped;
	} grid_result_t;

	localparam longint VALUE_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;

	// Predicted tables, agent position and register copies.
	logic signed [VALUE_BITS-1:0] state_value [CELLS];
	logic signed [VALUE_BITS-1:0] entry_reward [CELLS];
	logic                         wall_flag [CELLS];
	logic [ROW_W-1:0]             pos_row;
	logic [COL_W-1:0]             pos_col;
	logic [DIM_W-1:0]             rows_cfg;
	logic [DIM_W-1:0]             cols_cfg;
	logic [ROW_W-1:0]             goal_r;
	logic [COL_W-1:0]             goal_c;
	logic [FACTOR_W-1:0]          gamma_cfg;
	logic [FACTOR_W-1:0]          alpha_cfg;

	// Results still owed by the learner, oldest first.
	grid_result_t predicted_results [$];

	// Rounds a Q16.16 product with 16 extra fraction bits, half up.
	function automatic longint q16_round(input longint x);
		return (x + 64'sd32768) >>> FRAC_BITS;
	endfunction

	// Grid size in use: a zero size counts as one, a large one as the maximum.
	function automatic int dim_in_use(input logic [DIM_W-1:0] d, input int limit);
		if (d == 0)
			return 1;
		if (d > limit)
			return limit;
		return d;
	endfunction

	// Discount and learn rate saturate at 1.0.
	function automatic longint factor_in_use(input logic [FACTOR_W-1:0] f);
		return (f > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(f);
	endfunction

	// Works out the result of one item and advances the predicted state.
	task automatic run_grid_item(
		input  cmd_code_t                    op,
		input  logic [ROW_W-1:0]             r,
		input  logic [COL_W-1:0]             c,
		input  logic                         wall,
		input  logic signed [VALUE_BITS-1:0] reward,
		input  dir_t                         dir,
		output grid_result_t                 res
	);
		int     nr, nc, cur, nxt;
		longint vcur, delta, nv;
		res = '0;
		case (op)
			CMD_LOAD: begin
				wall_flag[{r, c}] = wall;
				entry_reward[{r, c}] = reward;
			end
			CMD_READ: begin
				res.value = state_value[{r, c}];
			end
			CMD_STEP: begin
				cur = {pos_row, pos_col};
				if (pos_row == goal_r && pos_col == goal_c) begin
					// Standing on the goal: the episode closes with no learning.
					res.value = state_value[cur];
					res.ended = 1'b1;
					pos_row = '0;
					pos_col = '0;
				end else begin
					nr = pos_row;
					nc = pos_col;
					case (dir)
						DIR_RIGHT: nc = nc + 1;
						DIR_DOWN:  nr = nr + 1;
						DIR_LEFT:  nc = nc - 1;
						DIR_UP:    nr = nr - 1;
					endcase
					// A move off the grid in use or into a wall leaves the agent in place.
					if (nr < 0 || nr >= dim_in_use(rows_cfg, MAX_ROWS) ||
					    nc < 0 || nc >= dim_in_use(cols_cfg, MAX_COLS)) begin
						nr = pos_row;
						nc = pos_col;
					end else if (wall_flag[nr * MAX_COLS + nc]) begin
						nr = pos_row;
						nc = pos_col;
					end
					nxt = nr * MAX_COLS + nc;

					// TD(0) update of the cell the agent leaves.
					vcur = state_value[cur];
					delta = longint'(entry_reward[nxt]) - vcur +
						q16_round(factor_in_use(gamma_cfg) * longint'(state_value[nxt]));
					nv = vcur + q16_round(factor_in_use(alpha_cfg) * delta);
					if (nv > VALUE_MAX) begin
						nv = VALUE_MAX;
						res.clamped = 1'b1;
					end
					if (nv < VALUE_MIN) begin
						nv = VALUE_MIN;
						res.clamped = 1'b1;
					end
					state_value[cur] = nv[VALUE_BITS-1:0];
					res.value = nv[VALUE_BITS-1:0];

					pos_row = nr[ROW_W-1:0];
					pos_col = nc[COL_W-1:0];
					if (pos_row == goal_r && pos_col == goal_c) begin
						res.ended = 1'b1;
						pos_row = '0;
						pos_col = '0;
					end
				end
			end
			default: begin
			end
		endcase
		res.row = pos_row;
		res.col = pos_col;
	endtask

	// Follows register writes and transfers on both channels.
	always @(posedge clk or negedge arst_n) begin
		grid_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				state_value[i] = '0;
				entry_reward[i] = '0;
				wall_flag[i] = 1'b0;
			end
			pos_row = '0;
			pos_col = '0;
			rows_cfg = RST_GRID_HEIGHT;
			cols_cfg = RST_GRID_WIDTH;
			goal_r = RST_GOAL_ROW;
			goal_c = RST_GOAL_COL;
			gamma_cfg = RST_DISCOUNT;
			alpha_cfg = RST_LEARN_RATE;
			predicted_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Register write.
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_HEIGHT: rows_cfg = cfg_data[DIM_W-1:0];
					REG_GRID_WIDTH:  cols_cfg = cfg_data[DIM_W-1:0];
					REG_GOAL_ROW:    goal_r = cfg_data[ROW_W-1:0];
					REG_GOAL_COL:    goal_c = cfg_data[COL_W-1:0];
					REG_DISCOUNT:    gamma_cfg = cfg_data[FACTOR_W-1:0];
					REG_LEARN_RATE:  alpha_cfg = cfg_data[FACTOR_W-1:0];
					default: begin
					end
				endcase
			end

			// Result transfer: compare with the oldest prediction.
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					if (fail_count < 10)
						$display("at %0t: result with no item awaiting it: %h/%0d/%0d/%b/%b",
							$time, value_out, agent_row, agent_col, episode_end, saturated);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (value_out !== want.value || agent_row !== want.row ||
					    agent_col !== want.col || episode_end !== want.ended ||
					    saturated !== want.clamped) begin
						if (fail_count < 10)
							$display("at %0t: result mismatch, expected %h/%0d/%0d/%b/%b,",
								$time, want.value, want.row, want.col, want.ended,
								want.clamped, " got %h/%0d/%0d/%b/%b",
								value_out, agent_row, agent_col, episode_end, saturated);
						fail_count++;
					end
				end
			end

			// Item transfer: predict its result.
			if (in_valid && in_ready) begin
				run_grid_item(cmd_code_t'(command), cell_row, cell_col, wall_bit, cell_reward,
					dir_t'(move_dir), want);
				predicted_results.push_back(want);
			end
			pending = predicted_results.size();
		end
	end

endmodule

@@ tb/tb_grid_td0_value_learner.sv @@
// Testbench top for the grid TD(0) value learner: stimulus, flow control and verdict.
module tb_grid_td0_value_learner;
	timeunit 1ns;
	timeprecision 1ps;
	import gtd_pkg::*;

	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = REG_GRID_HEIGHT;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [1:0]                   command = CMD_NOP;
	logic [ROW_W-1:0]             cell_row = '0;
	logic [COL_W-1:0]             cell_col = '0;
	logic                         wall_bit = 1'b0;
	logic signed [VALUE_BITS-1:0] cell_reward = '0;
	logic [1:0]                   move_dir = DIR_RIGHT;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [VALUE_BITS-1:0] value_out;
	logic [ROW_W-1:0]             agent_row;
	logic [COL_W-1:0]             agent_col;
	logic                         episode_end;
	logic                         saturated;

	int fail_count;
	int pending;

	// Idle rates of the two sides, in percent of cycles.
	int send_idle_pct = 28;
	int take_idle_pct = 75;

	// Grid area in use, for aiming loads and reads.
	int span_rows = 3;
	int span_cols = 4;

	// Agent position from the latest result.
	logic [ROW_W-1:0] last_row = '0;
	logic [COL_W-1:0] last_col = '0;

	int stall_cycles = 0;

	grid_td0_value_learner DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .command, .cell_row, .cell_col, .wall_bit, .cell_reward, .move_dir,
		.out_valid, .out_ready, .value_out, .agent_row, .agent_col, .episode_end, .saturated
	);

	td0_learner_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .command, .cell_row, .cell_col, .wall_bit, .cell_reward, .move_dir,
		.out_valid, .out_ready, .value_out, .agent_row, .agent_col, .episode_end, .saturated,
		.fail_count, .pending
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver stalls at random.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= take_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			last_row <= agent_row;
			last_col <= agent_col;
		end
	end

	// Watchdog: ends the run when nothing transfers for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One item on the input channel, after a random number of idle cycles.
	task automatic send_item(
		input cmd_code_t                    op,
		input logic [ROW_W-1:0]             r,
		input logic [COL_W-1:0]             c,
		input logic                         wall,
		input logic signed [VALUE_BITS-1:0] reward,
		input dir_t                         dir
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = op;
		cell_row = r;
		cell_col = c;
		wall_bit = wall;
		cell_reward = reward;
		move_dir = dir;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Waits until every result has been taken and the learner accepts again.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending != 0 || !in_ready)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
	endtask

	// Writes all six registers; unused upper data bits carry noise.
	task automatic configure(
		input logic [DIM_W-1:0]    h,
		input logic [DIM_W-1:0]    w,
		input logic [ROW_W-1:0]    gr,
		input logic [COL_W-1:0]    gc,
		input logic [FACTOR_W-1:0] gamma,
		input logic [FACTOR_W-1:0] alpha
	);
		write_reg(REG_GRID_HEIGHT, {12'($urandom), h});
		write_reg(REG_GRID_WIDTH, {12'($urandom), w});
		write_reg(REG_GOAL_ROW, {13'($urandom), gr});
		write_reg(REG_GOAL_COL, {13'($urandom), gc});
		write_reg(REG_DISCOUNT, gamma);
		write_reg(REG_LEARN_RATE, alpha);
		cfg_we = 1'b0;
		span_rows = (h == 0) ? 1 : (h > MAX_ROWS) ? MAX_ROWS : h;
		span_cols = (w == 0) ? 1 : (w > MAX_COLS) ? MAX_COLS : w;
	endtask

	initial begin
		int                           pick;
		int                           h;
		int                           w;
		cmd_code_t                    op;
		logic [ROW_W-1:0]             r;
		logic [COL_W-1:0]             c;
		logic [ROW_W-1:0]             gr;
		logic [COL_W-1:0]             gc;
		logic signed [VALUE_BITS-1:0] rew;
		logic [FACTOR_W-1:0]          gamma;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part on the 3x4 reset grid: field extremes, blocked moves, goal.
		send_item(CMD_READ, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_LOAD, 4'd0, 4'd1, 1'b0, 32'sh7FFF_FFFF, DIR_RIGHT);
		send_item(CMD_LOAD, 4'd1, 4'd0, 1'b1, 32'sh8000_0000, DIR_UP);
		send_item(CMD_LOAD, 4'd15, 4'd15, 1'b1, -32'sd1, DIR_LEFT);
		send_item(CMD_READ, 4'd15, 4'd15, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_UP);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_LEFT);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_DOWN);
		for (int i = 0; i < 4; i++)
			send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_DOWN);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_DOWN);
		send_item(CMD_NOP, 4'd15, 4'd15, 1'b1, -32'sd1, DIR_UP);
		send_item(CMD_READ, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_READ, 4'd0, 4'd1, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);

		// Goal moved onto the agent: the next step only closes the episode.
		wait_idle();
		write_reg(REG_GOAL_ROW, '0);
		write_reg(REG_GOAL_COL, 17'd1);
		cfg_we = 1'b0;
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_DOWN);

		// Goal at the start cell.
		wait_idle();
		write_reg(REG_GOAL_COL, '0);
		cfg_we = 1'b0;
		send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);
		send_item(CMD_READ, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);

		// Random phases, each with its own settings.
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = (p < 4) ? 28 : (p < 8) ? 75 : 0;
			take_idle_pct = (p < 4) ? 75 : (p < 8) ? 28 : 0;
			wait_idle();

			// Bring the agent home by putting the goal under it; one phase skips this
			// so that the agent may start outside a shrunk grid.
			if (p != 1) begin
				write_reg(REG_GOAL_ROW, CFG_DATA_W'(last_row));
				write_reg(REG_GOAL_COL, CFG_DATA_W'(last_col));
				cfg_we = 1'b0;
				send_item(CMD_STEP, 4'd0, 4'd0, 1'b0, 32'sd0, DIR_RIGHT);
				wait_idle();
			end

			case (p)
				0: configure(5'd16, 5'd16, 4'd15, 4'd15, FACTOR_ONE, FACTOR_ONE);
				1: configure(5'd2, 5'd2, 4'd1, 4'd1, '1, '1);
				2: configure(5'd0, 5'd31, 4'd0, 4'd15, '0, '0);
				3: configure(5'd31, 5'd0, 4'd15, 4'd0, FACTOR_W'($urandom_range(65536)),
					FACTOR_W'($urandom_range(65536)));
				4: configure(5'd4, 5'd4, 4'd0, 4'd0, FACTOR_W'($urandom_range(65536)),
					FACTOR_W'($urandom_range(65536)));
				default: begin
					h = $urandom_range(2, 6);
					w = $urandom_range(2, 6);
					// Now and then the goal lies outside the grid.
					gr = ($urandom_range(6) == 0) ? 4'($urandom) : 4'($urandom_range(h - 1));
					gc = ($urandom_range(6) == 0) ? 4'($urandom) : 4'($urandom_range(w - 1));
					gamma = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
					configure(DIM_W'(h), DIM_W'(w), gr, gc, gamma,
						FACTOR_W'($urandom_range(65536)));
				end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 55)
					op = CMD_STEP;
				else if (pick < 75)
					op = CMD_LOAD;
				else if (pick < 93)
					op = CMD_READ;
				else
					op = CMD_NOP;

				// Most loads and reads land inside the grid in use.
				r = ROW_W'($urandom);
				c = COL_W'($urandom);
				if ($urandom_range(9) < 8) begin
					r = ROW_W'($urandom_range(span_rows - 1));
					c = COL_W'($urandom_range(span_cols - 1));
				end

				// Rewards: most often within two units, some wide, some at the range limits.
				case ($urandom_range(9))
					0: begin
						case ($urandom_range(3))
							0: rew = 32'sh7FFF_FFFF;
							1: rew = 32'sh8000_0000;
							2: rew = 32'sd0;
							default: rew = -32'sd1;
						endcase
					end
					1, 2: rew = $urandom;
					3, 4, 5: rew = $urandom_range(33554431) - 32'sd16777216;
					default: rew = $urandom_range(262143) - 32'sd131072;
				endcase

				send_item(op, r, c, ($urandom_range(4) == 0), rew, dir_t'($urandom_range(3)));
			end
		end

		// Drain the remaining results, then give the verdict.
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
